// ----- design/bcbr_pkg.sv -----
// Shared constants, types and helpers for the button combo bind recorder.
package bcbr_pkg;

	localparam int NUM_BINDS = 16;
	localparam int ADDR_W    = (NUM_BINDS > 1) ? $clog2(NUM_BINDS) : 1;
	localparam int CNT_W     = ADDR_W + 1;

	// item kinds
	localparam logic [2:0] K_SAMPLE = 3'd0;
	localparam logic [2:0] K_BEGIN  = 3'd1;
	localparam logic [2:0] K_CANCEL = 3'd2;
	localparam logic [2:0] K_WRITE  = 3'd3;
	localparam logic [2:0] K_LOAD   = 3'd4;

	// recorder phases
	localparam logic [1:0] PH_OFF     = 2'd0;
	localparam logic [1:0] PH_WAIT    = 2'd1;
	localparam logic [1:0] PH_CAPTURE = 2'd2;

	// register indexes
	localparam logic REG_USABLE = 1'b0;
	localparam logic REG_MAXCNT = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_CHECK  = 5'b00100,
		ST_SWEEP  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	function automatic logic [2:0] pop4(input logic [3:0] v);
		pop4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
	endfunction

	function automatic logic [4:0] pop16(input logic [15:0] v);
		logic [3:0] lo;
		logic [3:0] hi;
		lo = 4'(pop4(v[3:0])) + 4'(pop4(v[7:4]));
		hi = 4'(pop4(v[11:8])) + 4'(pop4(v[15:12]));
		pop16 = 5'(lo) + 5'(hi);
	endfunction

endpackage

// ----- design/button_combo_bind_recorder.sv -----
// Button combo bind table with recorder, bind masks held in a synchronous RAM.
// Each accepted item passes through an execute state, a read-check-write state, a sweep of
// all NUM_BINDS entries through the RAM read port, and an output load.
// A new item is taken only in idle, so items never overlap; the output load waits on m_tready.
// Reset: async, active low; per-entry valid flops make the whole table read as zero
// at once, no clearing pass; registers return to usable 0xFFFF and max count 4.
module button_combo_bind_recorder (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // pad_buttons[15:0], bind_index[19:16], mask_value[35:20],
	                               // live_flag[36], zero[39:37]
	input  logic [2:0]  s_tuser,   // kind[2:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // held_hits[15:0], pressed_hits[31:16], recorder_phase[33:32],
	                               // recorder_muted[34], table_changed[35],
	                               // combo_committed[36], zero[39:37]
);

	localparam int NB = bcbr_pkg::NUM_BINDS;
	localparam int AW = bcbr_pkg::ADDR_W;
	localparam int CW = bcbr_pkg::CNT_W;

	bcbr_pkg::state_t state_q;

	logic [15:0] usable_q;
	logic [4:0]  maxcnt_q;

	// accepted item
	logic [2:0]  kind_q;
	logic [15:0] pad_q;
	logic [3:0]  idx_q;
	logic [15:0] mval_q;
	logic        live_q;

	// recorder state
	logic [15:0] held_now_q;
	logic [15:0] held_before_q;
	logic [15:0] accum_q;
	logic [1:0]  phase_q;
	logic [3:0]  target_q;
	logic        silent_q;
	logic        dirty_q;

	// pending bind write
	logic          wr_req_q;
	logic [AW-1:0] wr_addr_q;
	logic [15:0]   wr_mask_q;
	logic          wr_mark_q;
	logic          committed_q;

	// sweep
	logic [CW-1:0] sweep_q;
	logic [15:0]   held_hits_q;
	logic [15:0]   pressed_hits_q;

	// RAM
	logic [15:0]   mem [NB];
	logic [NB-1:0] valid_q;
	logic [15:0]   rd_data_s1;
	logic          rd_ok_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          rd_sweep_s1;
	logic [15:0]   rd_mask;

	logic [39:0] out_q;
	logic        out_valid_q;

	assign s_tready = (state_q == bcbr_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// ---------------- execute-stage decode ----------------
	logic [15:0]   held_new;
	logic [4:0]    held_cnt;
	logic          idx_ok;
	logic          ex_wr;
	logic [AW-1:0] ex_addr;
	logic [15:0]   ex_mask;
	logic          ex_mark;
	logic          ex_commit;
	logic [15:0]   n_held_now, n_held_before, n_accum;
	logic [1:0]    n_phase;
	logic [3:0]    n_target;
	logic          n_silent;

	assign held_new = pad_q & usable_q;
	assign held_cnt = bcbr_pkg::pop16(held_new);
	assign idx_ok   = ({1'b0, idx_q} < 5'(NB));

	always_comb begin
		logic        cm;
		logic [15:0] cm_mask;
		cm            = 1'b0;
		cm_mask       = '0;
		ex_wr         = 1'b0;
		ex_addr       = idx_q[AW-1:0];
		ex_mask       = mval_q & usable_q;
		ex_mark       = 1'b1;
		ex_commit     = 1'b0;
		n_held_now    = held_now_q;
		n_held_before = held_before_q;
		n_accum       = accum_q;
		n_phase       = phase_q;
		n_target      = target_q;
		n_silent      = silent_q;
		case (kind_q)
			bcbr_pkg::K_SAMPLE: begin
				n_held_before = held_now_q;
				n_held_now    = held_new;
				if (silent_q && phase_q == bcbr_pkg::PH_OFF && held_new == '0)
					n_silent = 1'b0;
				case (phase_q)
					bcbr_pkg::PH_WAIT: begin
						if (held_new == '0)
							n_phase = bcbr_pkg::PH_CAPTURE;
					end
					bcbr_pkg::PH_CAPTURE: begin
						if ((accum_q & ~held_new) != '0) begin
							cm      = 1'b1;
							cm_mask = accum_q;
						end else if (held_cnt >= maxcnt_q) begin
							cm      = 1'b1;
							cm_mask = held_new;
						end else begin
							n_accum = held_new;
						end
					end
					default: ;
				endcase
				if (cm) begin
					n_phase = bcbr_pkg::PH_OFF;
					n_accum = '0;
					if (cm_mask != '0) begin
						ex_commit = 1'b1;
						ex_wr     = ({1'b0, target_q} < 5'(NB));
						ex_addr   = target_q[AW-1:0];
						ex_mask   = cm_mask & usable_q;
					end
				end
			end
			bcbr_pkg::K_BEGIN: begin
				if (idx_ok) begin
					n_target = idx_q;
					n_accum  = '0;
					n_phase  = bcbr_pkg::PH_WAIT;
					n_silent = 1'b1;
				end
			end
			bcbr_pkg::K_CANCEL: begin
				n_phase = bcbr_pkg::PH_OFF;
				n_accum = '0;
			end
			bcbr_pkg::K_WRITE: begin
				ex_wr = idx_ok;
			end
			bcbr_pkg::K_LOAD: begin
				ex_wr   = idx_ok;
				ex_mark = 1'b0;
			end
			default: ;
		endcase
	end

	// ---------------- RAM ports ----------------
	// Reads happen in EXEC and SWEEP, the single write in CHECK, so the same entry is
	// never read and written at one edge.
	logic          rd_en;
	logic          rd_sweep;
	logic [AW-1:0] rd_addr;
	logic          mem_we;
	logic          mask_fits;

	assign rd_sweep  = (state_q == bcbr_pkg::ST_SWEEP) && (sweep_q < CW'(NB));
	assign rd_en     = (state_q == bcbr_pkg::ST_EXEC) || rd_sweep;
	assign rd_addr   = (state_q == bcbr_pkg::ST_EXEC) ? ex_addr : sweep_q[AW-1:0];
	assign mask_fits = (bcbr_pkg::pop16(wr_mask_q) <= maxcnt_q);
	assign mem_we    = (state_q == bcbr_pkg::ST_CHECK) && wr_req_q && mask_fits;
	assign rd_mask   = rd_ok_s1 ? rd_data_s1 : '0;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr_q] <= wr_mask_q;
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_ok_s1    <= 1'b0;
			rd_sweep_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			if (mem_we)
				valid_q[wr_addr_q] <= 1'b1;
			if (rd_en) begin
				rd_ok_s1  <= valid_q[rd_addr];
				rd_idx_s1 <= rd_addr;
			end
			rd_sweep_s1 <= rd_sweep;
		end
	end

	// ---------------- item capture ----------------
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			pad_q  <= s_tdata[15:0];
			idx_q  <= s_tdata[19:16];
			mval_q <= s_tdata[35:20];
			live_q <= s_tdata[36];
		end
		if (state_q == bcbr_pkg::ST_EXEC) begin
			wr_addr_q <= ex_addr;
			wr_mask_q <= ex_mask;
			wr_mark_q <= ex_mark;
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= bcbr_pkg::ST_IDLE;
			usable_q       <= 16'hFFFF;
			maxcnt_q       <= 5'd4;
			held_now_q     <= '0;
			held_before_q  <= '0;
			accum_q        <= '0;
			phase_q        <= bcbr_pkg::PH_OFF;
			target_q       <= '0;
			silent_q       <= 1'b0;
			dirty_q        <= 1'b0;
			wr_req_q       <= 1'b0;
			committed_q    <= 1'b0;
			sweep_q        <= '0;
			held_hits_q    <= '0;
			pressed_hits_q <= '0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bcbr_pkg::REG_USABLE: usable_q <= cfg_data;
					bcbr_pkg::REG_MAXCNT: maxcnt_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			// FINISH handles its own output handshake
			if (out_valid_q && m_tready && state_q != bcbr_pkg::ST_FINISH)
				out_valid_q <= 1'b0;

			case (state_q)
				bcbr_pkg::ST_IDLE: begin
					if (s_tvalid)
						state_q <= bcbr_pkg::ST_EXEC;
				end
				bcbr_pkg::ST_EXEC: begin
					held_now_q     <= n_held_now;
					held_before_q  <= n_held_before;
					accum_q        <= n_accum;
					phase_q        <= n_phase;
					target_q       <= n_target;
					silent_q       <= n_silent;
					wr_req_q       <= ex_wr;
					committed_q    <= ex_commit;
					held_hits_q    <= '0;
					pressed_hits_q <= '0;
					state_q        <= bcbr_pkg::ST_CHECK;
				end
				bcbr_pkg::ST_CHECK: begin
					// old entry is on the read port now
					if (mem_we && wr_mark_q && rd_mask != wr_mask_q)
						dirty_q <= 1'b1;
					sweep_q <= '0;
					state_q <= bcbr_pkg::ST_SWEEP;
				end
				bcbr_pkg::ST_SWEEP: begin
					if (rd_sweep)
						sweep_q <= sweep_q + 1'b1;
					if (rd_sweep_s1) begin
						if (live_q && rd_mask != '0 && held_now_q == rd_mask) begin
							held_hits_q[rd_idx_s1] <= 1'b1;
							if (held_before_q != rd_mask)
								pressed_hits_q[rd_idx_s1] <= 1'b1;
						end
						if (rd_idx_s1 == AW'(NB - 1))
							state_q <= bcbr_pkg::ST_FINISH;
					end
				end
				bcbr_pkg::ST_FINISH: begin
					if (!out_valid_q || m_tready) begin
						out_q       <= {3'b000, committed_q, dirty_q, silent_q, phase_q,
						                pressed_hits_q, held_hits_q};
						out_valid_q <= 1'b1;
						state_q     <= bcbr_pkg::ST_IDLE;
					end
				end
				default: state_q <= bcbr_pkg::ST_IDLE;
			endcase
		end
	end

	// ---------------- assertions ----------------
	a_we_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == bcbr_pkg::ST_CHECK))
		else $error("bind RAM written outside the check cycle");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == bcbr_pkg::ST_EXEC))
		else $error("accepted beat did not enter execute");

	a_commit_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[36]) |-> (m_tdata[33:32] == bcbr_pkg::PH_OFF))
		else $error("commit reported while recorder still active");

	a_accum_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(accum_q != '0) |-> (phase_q == bcbr_pkg::PH_CAPTURE))
		else $error("combo accumulator nonzero outside capture");

	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bcbr_pkg::ST_FINISH && (!out_valid_q || m_tready)) |=> out_valid_q)
		else $error("finished result not loaded into output register");

endmodule
